// ===== sv/assert_macros.svh =====
// Assertion macros shared by the RTL of the share evaluator.
// Depends on nothing; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, checked at every rising clock edge outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== sv/gfse_pkg.sv =====
// Types, constants and the GF(2^128) digit step of the share evaluator.
// Depends on nothing; used by every module of the block.
package gfse_pkg;

   localparam int FIELD_BITS  = 128;
   localparam int HALF_BITS   = 64;
   localparam int DIGIT_BITS  = 8;
   localparam int DIGITS      = FIELD_BITS / DIGIT_BITS;
   localparam int DIGIT_CNT_W = $clog2(DIGITS);
   localparam int COUNT_W     = 5;
   localparam int INDEX_W     = 4;
   localparam int REQ_DATA_W  = 136;
   localparam int RSP_DATA_W  = 256;

   localparam logic [DIGIT_BITS-1:0] REDUCE_POLY = 8'h87;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_EVAL = 1'b1;

   typedef logic [FIELD_BITS-1:0] field_type;

   typedef struct packed {
      logic busy;
      logic done;
   } mul_status_type;

   // One digit of a most-significant-first multiply: acc * x^8 + a * digit, reduced.
   function automatic field_type gf_digit_step(field_type acc, field_type a,
                                               logic [DIGIT_BITS-1:0] digit);
      logic [FIELD_BITS+DIGIT_BITS-1:0] wide;
      logic [DIGIT_BITS-1:0]            ovf;
      field_type                        res;
      wide = {acc, {DIGIT_BITS{1'b0}}};
      for (int j = 0; j < DIGIT_BITS; j++) begin
         if (digit[j]) begin
            wide = wide ^ ({{DIGIT_BITS{1'b0}}, a} << j);
         end
      end
      ovf = wide[FIELD_BITS+DIGIT_BITS-1:FIELD_BITS];
      res = wide[FIELD_BITS-1:0];
      for (int j = 0; j < DIGIT_BITS; j++) begin
         if (ovf[j]) begin
            res = res ^ ({{(FIELD_BITS-DIGIT_BITS){1'b0}}, REDUCE_POLY} << j);
         end
      end
      return res;
   endfunction

endpackage

// ===== sv/gfse_coeff_ram.sv =====
// Coefficient store: one write port, one registered read port, valid bits per entry.
// Depends on gfse_pkg.
module gfse_coeff_ram #(
   parameter int DEPTH  = 16,
   parameter int ADDR_W = 4
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 wr_en,
   input  logic [ADDR_W-1:0]    wr_addr,
   input  gfse_pkg::field_type  wr_data,
   input  logic                 rd_en,
   input  logic [ADDR_W-1:0]    rd_addr,
   output gfse_pkg::field_type  rd_data
);

   gfse_pkg::field_type mem [DEPTH];
   logic [DEPTH-1:0]    valid_ff;
   gfse_pkg::field_type rd_data_ff;
   logic                rd_valid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_valid_ff <= valid_ff[rd_addr];
         end
      end
   end

   assign rd_data = rd_valid_ff ? rd_data_ff : '0;

endmodule

// ===== sv/gfse_mult.sv =====
// Digit-serial GF(2^128) multiplier, eight bits of the second operand per cycle.
// Depends on gfse_pkg.
module gfse_mult (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  gfse_pkg::field_type      operand_a,
   input  gfse_pkg::field_type      operand_b,
   output gfse_pkg::field_type      product,
   output gfse_pkg::mul_status_type status
);

   gfse_pkg::field_type                 acc_ff, acc_in;
   gfse_pkg::field_type                 a_ff, a_in;
   gfse_pkg::field_type                 b_ff, b_in;
   logic [gfse_pkg::DIGIT_CNT_W-1:0]    cnt_ff, cnt_in;
   logic                                busy_ff, busy_in;
   logic                                done_ff, done_in;

   always_comb begin
      acc_in  = acc_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         acc_in  = '0;
         a_in    = operand_a;
         b_in    = operand_b;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         acc_in = gfse_pkg::gf_digit_step(acc_ff, a_ff,
            b_ff[gfse_pkg::FIELD_BITS-1 -: gfse_pkg::DIGIT_BITS]);
         b_in   = b_ff << gfse_pkg::DIGIT_BITS;
         cnt_in = cnt_ff + gfse_pkg::DIGIT_CNT_W'(1);
         if (cnt_ff == gfse_pkg::DIGIT_CNT_W'(gfse_pkg::DIGITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
      cnt_ff <= cnt_in;
   end

   assign product     = acc_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

// ===== sv/gf128_share_evaluator.sv =====
// Top level of the GF(2^128) share evaluator: sequencer, result register, count register.
// Depends on gfse_pkg, gfse_coeff_ram, gfse_mult and assert_macros.svh.
//
//   channel   direction   transfer carries
//   req_      in          opcode in tuser, coeff_index and the 128-bit value in tdata
//   rsp_      out         share x and share y in tdata, one per evaluate
//   csr_      in          coeff_count, five bits
//
// An evaluate of n coefficients runs a Horner loop from the highest index down:
// each Horner step is one pass of the eight-bit digit-serial multiplier, and the
// coefficient read from the store is added as that pass ends and the next pass starts.
// Reset clears the coefficient store at once through per-entry valid bits.
// A finished share waits in the output register; the next item is taken meanwhile,
// and an evaluate that finishes while that register is still full holds until it drains.
`include "assert_macros.svh"

module gf128_share_evaluator #(
   parameter int MAX_COEFFS = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // [3:0] coeff_index, [67:4] value_low, [131:68] value_high, [135:132] zero
   input  logic [135:0] req_tdata,
   // [0] opcode
   input  logic [0:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // [63:0] share_x_low, [127:64] share_x_high, [191:128] share_y_low, [255:192] share_y_high
   output logic [255:0] rsp_tdata,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [4:0]   csr_data
);

   localparam int ADDR_W = $clog2(MAX_COEFFS);
   localparam int CNT_W  = $clog2(MAX_COEFFS + 1);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_WAIT = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   logic [1:0]                        state_ff, state_in;
   gfse_pkg::field_type               x_ff, x_in;
   gfse_pkg::field_type               y_ff, y_in;
   logic [ADDR_W-1:0]                 idx_ff, idx_in;
   logic [gfse_pkg::COUNT_W-1:0]      count_ff, count_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [gfse_pkg::RSP_DATA_W-1:0]   rsp_data_ff, rsp_data_in;

   logic                              req_fire;
   logic                              req_opcode;
   logic [gfse_pkg::INDEX_W-1:0]      req_index;
   gfse_pkg::field_type               req_value;
   logic                              load_in_range;
   logic [CNT_W-1:0]                  n_eff;
   logic [ADDR_W-1:0]                 first_idx;
   logic                              slot_free;

   logic                              wr_en;
   logic                              rd_en;
   logic [ADDR_W-1:0]                 rd_addr;
   gfse_pkg::field_type               coeff;
   logic                              mul_start;
   gfse_pkg::field_type               mul_a;
   gfse_pkg::field_type               mul_b;
   gfse_pkg::field_type               mul_product;
   gfse_pkg::mul_status_type          mul_status;
   gfse_pkg::field_type               y_next;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid & req_tready;
   assign req_opcode = req_tuser[0];
   assign req_index  = req_tdata[gfse_pkg::INDEX_W-1:0];
   assign req_value  = req_tdata[gfse_pkg::INDEX_W +: gfse_pkg::FIELD_BITS];
   assign csr_ready  = 1'b1;

   assign load_in_range = (int'(req_index) < MAX_COEFFS);
   assign n_eff     = (int'(count_ff) > MAX_COEFFS) ? CNT_W'(MAX_COEFFS) : CNT_W'(count_ff);
   assign first_idx = ADDR_W'(n_eff - CNT_W'(1));
   assign slot_free = ~rsp_valid_ff | rsp_tready;
   assign y_next    = mul_product ^ coeff;

   gfse_coeff_ram #(
      .DEPTH  (MAX_COEFFS),
      .ADDR_W (ADDR_W)
   ) u_coeff_ram (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (wr_en),
      .wr_addr (ADDR_W'(req_index)),
      .wr_data (req_value),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (coeff)
   );

   gfse_mult u_mult (
      .clock     (clock),
      .reset     (reset),
      .start     (mul_start),
      .operand_a (mul_a),
      .operand_b (mul_b),
      .product   (mul_product),
      .status    (mul_status)
   );

   always_comb begin
      state_in     = state_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      idx_in       = idx_ff;
      count_in     = csr_valid ? csr_data : count_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_data_in  = rsp_data_ff;
      wr_en        = 1'b0;
      rd_en        = 1'b0;
      rd_addr      = idx_ff;
      mul_start    = 1'b0;
      mul_a        = '0;
      mul_b        = x_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_opcode == gfse_pkg::OP_LOAD) begin
                  wr_en = load_in_range;
               end else begin
                  x_in = req_value;
                  if (n_eff == '0) begin
                     y_in     = '0;
                     state_in = ST_DONE;
                  end else begin
                     idx_in    = first_idx;
                     rd_en     = 1'b1;
                     rd_addr   = first_idx;
                     mul_start = 1'b1;
                     mul_a     = '0;
                     mul_b     = req_value;
                     state_in  = ST_WAIT;
                  end
               end
            end
         end
         ST_WAIT: begin
            if (mul_status.done) begin
               if (idx_ff == '0) begin
                  y_in     = y_next;
                  state_in = ST_DONE;
               end else begin
                  idx_in    = idx_ff - ADDR_W'(1);
                  rd_en     = 1'b1;
                  rd_addr   = idx_ff - ADDR_W'(1);
                  mul_start = 1'b1;
                  mul_a     = y_next;
                  mul_b     = x_ff;
               end
            end
         end
         ST_DONE: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {y_ff, x_ff};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         count_ff     <= gfse_pkg::COUNT_W'(1);
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff        <= x_in;
      y_ff        <= y_in;
      idx_ff      <= idx_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   `ASSERT_IMP(a_start_when_free, clock, reset, mul_start, !mul_status.busy)
   `ASSERT_IMP(a_done_in_wait, clock, reset, mul_status.done, state_ff == ST_WAIT)
   `ASSERT_IMP(a_busy_blocks_input, clock, reset, mul_status.busy, !req_tready)
   `ASSERT_NEXT(a_share_posted, clock, reset, (state_ff == ST_DONE) && slot_free, rsp_tvalid)

endmodule
